### design/tbww_pkg.sv
// Shared types and constants of the text box word wrap block.
// Used by tbww_front, tbww_back and text_box_word_wrap; no dependencies.
package tbww_pkg;

   localparam int ROW_W  = 3;
   localparam int COL_W  = 5;
   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_END     = 8'd0;

   typedef enum logic [1:0] {
      CLS_CHAR,
      CLS_SPACE,
      CLS_NEWLINE,
      CLS_END
   } char_class_type;

   typedef struct packed {
      char_class_type      cls;
      logic [CHAR_W-1:0]   ch;
   } queue_item_type;

endpackage

### design/tbww_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tbww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tbww_front.sv
// Front end: accepts text bytes, classifies them and holds them in a
// two-entry queue for the back end. Depends on tbww_pkg.
module tbww_front
   import tbww_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_text_byte,
   output logic              q_valid,
   output queue_item_type    q_item,
   input  logic              q_pop
);

   queue_item_type entry_ff [2];
   logic           wptr_ff, wptr_in;
   logic           rptr_ff, rptr_in;
   logic [1:0]     count_ff, count_in;
   queue_item_type new_item;
   logic           push;

   always_comb begin
      new_item.ch = req_text_byte;
      if (req_text_byte == CH_END) begin
         new_item.cls = CLS_END;
      end else if (req_text_byte == CH_SPACE) begin
         new_item.cls = CLS_SPACE;
      end else if (req_text_byte == CH_NEWLINE) begin
         new_item.cls = CLS_NEWLINE;
      end else begin
         new_item.cls = CLS_CHAR;
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = q_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= new_item;
      end
   end

endmodule

### design/tbww_back.sv
// Back end: holds the current word in a RAM, places it by greedy wrap and
// drives cell writes through an output register. Depends on tbww_pkg, tbww_ram.
module tbww_back
   import tbww_pkg::*;
#(
   parameter int BOX_WIDTH = 32,
   parameter int BOX_ROWS  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  queue_item_type    q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_cell_row,
   output logic [COL_W-1:0]  rsp_cell_col,
   output logic [CHAR_W-1:0] rsp_cell_char,
   output logic              rsp_run_last
);

   localparam int CW = $clog2(BOX_WIDTH + 1);
   localparam int RW = $clog2(BOX_ROWS + 1);
   localparam int AW = $clog2(BOX_WIDTH);
   localparam logic [CW-1:0] WIDTH_C = CW'(BOX_WIDTH);
   localparam logic [CW:0]   WIDTH_X = (CW + 1)'(BOX_WIDTH);
   localparam logic [RW:0]   ROWS_X  = (RW + 1)'(BOX_ROWS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_TAIL
   } state_type;

   typedef enum logic [1:0] {
      TL_SPACE,
      TL_NEWLINE,
      TL_LONGCH,
      TL_END
   } tail_type;

   state_type         state_ff, state_in;
   tail_type          tail_ff, tail_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [CW-1:0]     wc_ff, wc_in;
   logic              long_ff, long_in;
   logic              full_ff, full_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              emit;
   logic [RW-1:0]     emit_row;
   logic [CW-1:0]     emit_col;
   logic [CHAR_W-1:0] emit_char;
   logic              emit_last;
   logic [RW+2:0]     emit_row_wide;
   logic [CW+4:0]     emit_col_wide;

   logic [CW:0]       col_plus_wc;
   logic [CW:0]       col_plus_one;
   logic              need_nr;
   logic              row_ovf;
   logic              tail_emit;
   logic              at_last;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [CHAR_W-1:0] ram_rdata;

   tbww_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(BOX_WIDTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_item.ch),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign col_plus_wc  = {1'b0, col_ff} + {1'b0, wc_ff};
   assign col_plus_one = {1'b0, col_ff} + 1'b1;
   assign need_nr      = (col_ff != '0) && (col_plus_wc > WIDTH_X);
   assign row_ovf      = ({1'b0, row_ff} + 1'b1) >= ROWS_X;
   assign tail_emit    = ((tail_ff == TL_SPACE) && (col_plus_one < WIDTH_X)) ||
                         ((tail_ff == TL_LONGCH) && !row_ovf);
   assign at_last      = (idx_ff == last_ff);
   assign ram_waddr    = AW'(wc_ff);

   always_comb begin
      state_in  = state_ff;
      tail_in   = tail_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      wc_in     = wc_ff;
      long_in   = long_ff;
      full_in   = full_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      ch_in     = ch_ff;
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      emit      = 1'b0;
      emit_row  = row_ff;
      emit_col  = col_ff;
      emit_char = ch_ff;
      emit_last = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               ch_in = q_item.ch;
               if (q_item.cls == CLS_END) begin
                  if (!full_ff && !long_ff && (wc_ff != '0) && !(need_nr && row_ovf)) begin
                     if (need_nr) begin
                        row_in = row_ff + 1'b1;
                        col_in = '0;
                     end
                     last_in  = AW'(wc_ff - 1'b1);
                     idx_in   = '0;
                     wc_in    = '0;
                     long_in  = 1'b0;
                     tail_in  = TL_END;
                     state_in = ST_FLUSH;
                  end else begin
                     row_in  = '0;
                     col_in  = '0;
                     wc_in   = '0;
                     long_in = 1'b0;
                     full_in = 1'b0;
                  end
               end else if (full_ff) begin
                  // drop until the terminator
               end else if (q_item.cls == CLS_SPACE || q_item.cls == CLS_NEWLINE) begin
                  tail_in = (q_item.cls == CLS_SPACE) ? TL_SPACE : TL_NEWLINE;
                  wc_in   = '0;
                  long_in = 1'b0;
                  if (!long_ff && (wc_ff != '0)) begin
                     if (need_nr && row_ovf) begin
                        row_in  = row_ff + 1'b1;
                        col_in  = '0;
                        full_in = 1'b1;
                     end else begin
                        if (need_nr) begin
                           row_in = row_ff + 1'b1;
                           col_in = '0;
                        end
                        last_in  = AW'(wc_ff - 1'b1);
                        idx_in   = '0;
                        state_in = ST_FLUSH;
                     end
                  end else begin
                     state_in = ST_TAIL;
                  end
               end else if (long_ff) begin
                  tail_in  = TL_LONGCH;
                  state_in = ST_TAIL;
               end else if (wc_ff < WIDTH_C) begin
                  ram_we = 1'b1;
                  wc_in  = wc_ff + 1'b1;
               end else begin
                  if ((col_ff != '0) && row_ovf) begin
                     row_in  = row_ff + 1'b1;
                     col_in  = '0;
                     full_in = 1'b1;
                     wc_in   = '0;
                     long_in = 1'b0;
                  end else begin
                     if (col_ff != '0) begin
                        row_in = row_ff + 1'b1;
                        col_in = '0;
                     end
                     last_in  = AW'(wc_ff - 1'b1);
                     idx_in   = '0;
                     wc_in    = '0;
                     long_in  = 1'b1;
                     tail_in  = TL_LONGCH;
                     state_in = ST_FLUSH;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = ram_rdata;
               emit_last = at_last && !tail_emit;
               col_in    = col_ff + 1'b1;
               if (at_last) begin
                  state_in = ST_TAIL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_TAIL: begin
            case (tail_ff)
               TL_SPACE: begin
                  if ((col_ff != '0) && (col_ff < WIDTH_C)) begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_char = CH_SPACE;
                        col_in    = col_ff + 1'b1;
                        state_in  = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               TL_NEWLINE: begin
                  row_in   = row_ff + 1'b1;
                  col_in   = '0;
                  full_in  = row_ovf;
                  state_in = ST_IDLE;
               end
               TL_LONGCH: begin
                  if (col_ff >= WIDTH_C) begin
                     if (row_ovf) begin
                        row_in   = row_ff + 1'b1;
                        col_in   = '0;
                        full_in  = 1'b1;
                        long_in  = 1'b0;
                        state_in = ST_IDLE;
                     end else if (out_free) begin
                        emit     = 1'b1;
                        emit_row = row_ff + 1'b1;
                        emit_col = '0;
                        row_in   = row_ff + 1'b1;
                        col_in   = CW'(1);
                        long_in  = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else if (out_free) begin
                     emit     = 1'b1;
                     col_in   = col_ff + 1'b1;
                     long_in  = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               TL_END: begin
                  row_in   = '0;
                  col_in   = '0;
                  wc_in    = '0;
                  long_in  = 1'b0;
                  full_in  = 1'b0;
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign emit_row_wide = (RW + 3)'(emit_row);
   assign emit_col_wide = (CW + 5)'(emit_col);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = emit_row_wide[ROW_W-1:0];
         rsp_col_in   = emit_col_wide[COL_W-1:0];
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_ff      <= TL_END;
         row_ff       <= '0;
         col_ff       <= '0;
         wc_ff        <= '0;
         long_ff      <= 1'b0;
         full_ff      <= 1'b0;
         idx_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wc_ff        <= wc_in;
         long_ff      <= long_in;
         full_ff      <= full_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_row  = rsp_row_ff;
   assign rsp_cell_col  = rsp_col_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

### design/text_box_word_wrap.sv
// Text box word wrap: greedy wrap of a byte string into a box of cell writes.
// Items pass through the two-entry front queue, the back end and the output register.
// A word byte is written to the word RAM when popped; a space, newline or long-word
// byte can first place the held word bytes, and the back end pops no byte meanwhile.
// Reset: synchronous, clears position, word count, modes and queue; word RAM is
// not cleared. Depends on tbww_pkg, tbww_front, tbww_back.
module text_box_word_wrap
   import tbww_pkg::*;
#(
   parameter int BOX_WIDTH = 32,
   parameter int BOX_ROWS  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_text_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_cell_row,
   output logic [COL_W-1:0]  rsp_cell_col,
   output logic [CHAR_W-1:0] rsp_cell_char,
   output logic              rsp_run_last
);

   logic           q_valid;
   logic           q_pop;
   queue_item_type q_item;

   tbww_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   tbww_back #(
      .BOX_WIDTH(BOX_WIDTH),
      .BOX_ROWS (BOX_ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_cell_char (rsp_cell_char),
      .rsp_run_last  (rsp_run_last)
   );

endmodule
